// File: hdl/palette_gradient_generator_macros.svh
// ----------------------------------------------------------------------------
// Palette gradient generator assertion macros
// Shared concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PALETTE_GRADIENT_GENERATOR_MACROS_SVH
`define PALETTE_GRADIENT_GENERATOR_MACROS_SVH

// same-cycle implication
`define PGG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PGG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/pgg_pkg.sv
// ----------------------------------------------------------------------------
// Palette gradient generator package
// Types, field widths and the channel level helper.
// ----------------------------------------------------------------------------
package pgg_pkg;

   localparam int IDX_W    = 6;
   localparam int LVL_W    = 8;
   localparam int FRAC_W   = 16;
   localparam int ACC_W    = LVL_W + FRAC_W;   // unsigned Q8.16
   localparam int STEP_W   = ACC_W + 1;        // signed Q9.16
   localparam int SHIFT_W  = 3;
   localparam int CHAN_W   = 5;
   localparam int COLOR_W  = 3 * CHAN_W;
   localparam int DIVCNT_W = 5;

   localparam logic [SHIFT_W-1:0]  SHIFT_RESET = 3'd3;
   localparam logic [CHAN_W-1:0]   LEVEL_MAX   = 5'd31;
   localparam logic [DIVCNT_W-1:0] DIV_LAST    = 5'(ACC_W - 1);

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // integer part, shifted, clamped to five bits
   function automatic logic [CHAN_W-1:0] chan_level(input logic [ACC_W-1:0]   acc,
                                                    input logic [SHIFT_W-1:0] sh);
      logic [LVL_W-1:0] v;
      v = acc[ACC_W-1:FRAC_W] >> sh;
      return (v > LVL_W'(LEVEL_MAX)) ? LEVEL_MAX : v[CHAN_W-1:0];
   endfunction

endpackage

// File: hdl/palette_gradient_generator.sv
// A request with first < last passes through the shared divider, three channels
// in turn (one load plus 24 quotient bits each), then emits one entry per cycle
// while rsp_tready does not stall it. A single-entry request skips the divider;
// empty requests are dropped. A new request is taken only once the block is idle.
// Reset (synchronous, active high): idle, no result pending, channel_shift = 3.
// ----------------------------------------------------------------------------
// Palette gradient generator
// Linear RGB555 gradient over a palette index range, Q9.16 steps from a
// restoring bit-serial divider shared by the three channels.
// ----------------------------------------------------------------------------
`include "palette_gradient_generator_macros.svh"

module palette_gradient_generator #(
   parameter int PALETTE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [pgg_pkg::SHIFT_W-1:0] csr_wr_data,  // channel_shift
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_index, last_index, start_red, start_green, start_blue,
   // end_red, end_green, end_blue, zero pad
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // palette_index, color, zero pad
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);
   import pgg_pkg::*;

   localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(PALETTE_ENTRIES - 1);

   // request fields
   logic [IDX_W-1:0] first_index, last_index;
   logic [LVL_W-1:0] start_lvl [3];
   logic [LVL_W-1:0] end_lvl   [3];

   assign first_index  = req_tdata[5:0];
   assign last_index   = req_tdata[11:6];
   assign start_lvl[0] = req_tdata[19:12];
   assign start_lvl[1] = req_tdata[27:20];
   assign start_lvl[2] = req_tdata[35:28];
   assign end_lvl[0]   = req_tdata[43:36];
   assign end_lvl[1]   = req_tdata[51:44];
   assign end_lvl[2]   = req_tdata[59:52];

   // control
   state_type            state_ff, state_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic [1:0]                chan_ff, chan_in;
   logic [DIVCNT_W-1:0]       bit_ff, bit_in;
   logic [IDX_W-1:0]          rem_ff, rem_in;
   logic [ACC_W-1:0]          quo_ff, quo_in;
   logic                      neg_ff, neg_in;
   logic [IDX_W-1:0]          span_ff, span_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [IDX_W-1:0]          stop_ff, stop_in;
   logic [LVL_W-1:0]          end_ff [3];
   logic [LVL_W-1:0]          end_in [3];
   logic [ACC_W-1:0]          acc_ff [3];
   logic [ACC_W-1:0]          acc_in [3];
   logic signed [STEP_W-1:0]  step_ff [3];
   logic signed [STEP_W-1:0]  step_in [3];
   logic [IDX_W-1:0]          out_idx_ff, out_idx_in;
   logic [COLOR_W-1:0]        out_color_ff, out_color_in;
   logic                      out_last_ff, out_last_in;

   // shared divider datapath
   logic [IDX_W:0]   rem_shift;
   logic [IDX_W:0]   rem_sub;
   logic             q_bit;
   logic [LVL_W-1:0] diff_mag;
   logic             diff_neg;
   logic [LVL_W-1:0] start_cur;
   logic             emit_go;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[ACC_W-1]};
      rem_sub   = rem_shift - {1'b0, span_ff};
      q_bit     = (rem_shift >= {1'b0, span_ff});
      start_cur = acc_ff[chan_ff][ACC_W-1:FRAC_W];
      diff_neg  = (end_ff[chan_ff] < start_cur);
      diff_mag  = diff_neg ? (start_cur - end_ff[chan_ff]) : (end_ff[chan_ff] - start_cur);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign emit_go    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      shift_in     = csr_wr_en ? csr_wr_data : shift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      chan_in      = chan_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      span_in      = span_ff;
      idx_in       = idx_ff;
      stop_in      = stop_ff;
      end_in       = end_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      out_idx_in   = out_idx_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in  = first_index;
               stop_in = (last_index > LAST_ENTRY) ? LAST_ENTRY : last_index;
               span_in = last_index - first_index;
               chan_in = CH_RED;
               for (int c = 0; c < 3; c++) begin
                  end_in[c]  = end_lvl[c];
                  acc_in[c]  = {start_lvl[c], {FRAC_W{1'b0}}};
                  step_in[c] = '0;
               end
               if (last_index < first_index || first_index > LAST_ENTRY) begin
                  state_in = ST_IDLE;
               end else if (last_index == first_index) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            quo_in   = {diff_mag, {FRAC_W{1'b0}}};
            neg_in   = diff_neg;
            rem_in   = '0;
            bit_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in = q_bit ? rem_sub[IDX_W-1:0] : rem_shift[IDX_W-1:0];
            quo_in = {quo_ff[ACC_W-2:0], q_bit};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == DIV_LAST) begin
               step_in[chan_ff] = neg_ff ? -$signed({1'b0, quo_in}) : $signed({1'b0, quo_in});
               if (chan_ff == CH_BLUE) begin
                  state_in = ST_EMIT;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               out_idx_in   = idx_ff;
               out_color_in = {chan_level(acc_ff[0], shift_ff),
                               chan_level(acc_ff[1], shift_ff),
                               chan_level(acc_ff[2], shift_ff)};
               out_last_in  = (idx_ff == stop_ff);
               for (int c = 0; c < 3; c++) begin
                  acc_in[c] = ACC_W'($signed({1'b0, acc_ff[c]}) + step_ff[c]);
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == stop_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_ff     <= SHIFT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff      <= chan_in;
      bit_ff       <= bit_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      span_ff      <= span_in;
      idx_ff       <= idx_in;
      stop_ff      <= stop_in;
      end_ff       <= end_in;
      acc_ff       <= acc_in;
      step_ff      <= step_in;
      out_idx_ff   <= out_idx_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_color_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;

   `PGG_ASSERT_IMP(a_emit_in_range, clock, reset, state_ff == ST_EMIT, idx_ff <= stop_ff)
   `PGG_ASSERT_IMP(a_div_span, clock, reset, state_ff == ST_DIVIDE, span_ff != '0)
   `PGG_ASSERT_IMP(a_div_count, clock, reset, state_ff == ST_DIVIDE, bit_ff <= DIV_LAST)
   `PGG_ASSERT_NXT(a_load_to_div, clock, reset, state_ff == ST_LOAD, state_ff == ST_DIVIDE)
   `PGG_ASSERT_IMP(a_div_chan, clock, reset, state_ff != ST_IDLE, chan_ff <= CH_BLUE)

endmodule
